[hw/rtl/uart_drb_pkg.sv]
// Shared types for the dual ring buffer unit.
// Event codes and the command and status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package uart_drb_pkg;

    typedef enum logic [1:0] {
        CMD_LINE_RX  = 2'd0,
        CMD_APP_READ = 2'd1,
        CMD_APP_WRITE = 2'd2,
        CMD_TX_READY = 2'd3
    } cmd_t;

    typedef struct packed {
        logic capture;
        logic execute;
        logic fetch;
        logic load;
    } drb_ctrl_t;

    typedef struct packed {
        logic out_busy;
    } drb_status_t;

endpackage

[hw/rtl/uart_drb_ctrl.sv]
// Controller state machine for the dual ring buffer unit.
// Sequences capture, ring update, transmit fetch and result load; uses uart_drb_pkg.
`timescale 1ns / 1ps

module uart_drb_ctrl
    import uart_drb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  drb_status_t status,
    output drb_ctrl_t   ctrl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FETCH,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   in_ready_next;

    always_comb
    begin
        state_next    = state_reg;
        in_ready_next = in_ready_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    state_next    = S_EXEC;
                    in_ready_next = 1'b0;
                end
            end
            S_EXEC:
            begin
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!status.out_busy)
                begin
                    state_next    = S_IDLE;
                    in_ready_next = 1'b1;
                end
            end
            default:
            begin
                state_next    = S_IDLE;
                in_ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= in_ready_next;
        end
    end

    assign in_ready     = in_ready_reg;
    assign ctrl.capture = in_valid && in_ready_reg;
    assign ctrl.execute = (state_reg == S_EXEC);
    assign ctrl.fetch   = (state_reg == S_FETCH);
    assign ctrl.load    = (state_reg == S_DONE) && !status.out_busy;

endmodule

[hw/rtl/uart_drb_datapath.sv]
// Datapath for the dual ring buffer unit: both ring memories, pointers, fill counts
// and the result register. Driven by uart_drb_ctrl; uses uart_drb_pkg.
`timescale 1ns / 1ps

module uart_drb_datapath
    import uart_drb_pkg::*;
#(
    parameter int RING_DEPTH = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  drb_ctrl_t   ctrl,
    output drb_status_t status,
    input  logic [1:0]  cmd,
    input  logic [7:0]  data_byte,
    input  logic        tx_room,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        read_valid,
    output logic [7:0]  read_data,
    output logic        send_valid,
    output logic [7:0]  send_data,
    output logic        rx_pending,
    output logic [7:0]  tx_free,
    output logic        overflow
);

    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int FREE_W = (PTR_W > 8) ? PTR_W : 8;
    localparam logic [PTR_W-1:0] LAST = PTR_W'(RING_DEPTH - 1);

    logic [7:0] rx_mem [RING_DEPTH];
    logic [7:0] tx_mem [RING_DEPTH];

    cmd_t       cmd_reg;
    logic [7:0] byte_reg;
    logic       room_reg;

    logic [PTR_W-1:0] rx_head_reg, rx_tail_reg, rx_count_reg;
    logic [PTR_W-1:0] tx_head_reg, tx_tail_reg, tx_count_reg;
    logic [7:0]       rx_rdata_reg, tx_rdata_reg;
    logic             rv_reg, sv_reg, ovf_reg;

    logic       out_valid_reg;
    logic       read_valid_reg, send_valid_reg, rx_pending_reg, overflow_reg;
    logic [7:0] read_data_reg, send_data_reg, tx_free_reg;

    logic rx_full, tx_full;
    logic rx_wr_en, rx_rd_en, tx_wr_en, tx_rd_en;
    logic [FREE_W-1:0] free_ext;
    logic [7:0]        free_sat;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == LAST) ? '0 : p + 1'b1;
    endfunction

    assign rx_full  = (rx_count_reg == LAST);
    assign tx_full  = (tx_count_reg == LAST);
    assign rx_wr_en = ctrl.execute && (cmd_reg == CMD_LINE_RX) && !rx_full;
    assign rx_rd_en = ctrl.execute && (cmd_reg == CMD_APP_READ) && (rx_count_reg != '0);
    assign tx_wr_en = ctrl.execute && (cmd_reg == CMD_APP_WRITE) && !tx_full;
    assign tx_rd_en = ctrl.fetch && (cmd_reg inside {CMD_APP_WRITE, CMD_TX_READY})
                      && (tx_count_reg != '0) && room_reg;

    assign free_ext = FREE_W'(RING_DEPTH - 1) - FREE_W'(tx_count_reg);
    assign free_sat = (free_ext > FREE_W'(255)) ? 8'hFF : free_ext[7:0];

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg  <= cmd_t'(cmd);
            byte_reg <= data_byte;
            room_reg <= tx_room;
        end
        if (rx_wr_en)
            rx_mem[rx_head_reg] <= byte_reg;
        if (rx_rd_en)
            rx_rdata_reg <= rx_mem[rx_tail_reg];
        if (tx_wr_en)
            tx_mem[tx_head_reg] <= byte_reg;
        if (tx_rd_en)
            tx_rdata_reg <= tx_mem[tx_tail_reg];
        if (ctrl.load)
        begin
            read_valid_reg <= rv_reg;
            read_data_reg  <= rv_reg ? rx_rdata_reg : 8'h00;
            send_valid_reg <= sv_reg;
            send_data_reg  <= sv_reg ? tx_rdata_reg : 8'h00;
            rx_pending_reg <= (rx_count_reg != '0);
            tx_free_reg    <= free_sat;
            overflow_reg   <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_head_reg   <= '0;
            rx_tail_reg   <= '0;
            rx_count_reg  <= '0;
            tx_head_reg   <= '0;
            tx_tail_reg   <= '0;
            tx_count_reg  <= '0;
            rv_reg        <= 1'b0;
            sv_reg        <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.capture)
            begin
                rv_reg  <= 1'b0;
                sv_reg  <= 1'b0;
                ovf_reg <= 1'b0;
            end
            if (ctrl.execute && (((cmd_reg == CMD_LINE_RX) && rx_full)
                || ((cmd_reg == CMD_APP_WRITE) && tx_full)))
                ovf_reg <= 1'b1;
            if (rx_wr_en)
            begin
                rx_head_reg  <= bump(rx_head_reg);
                rx_count_reg <= rx_count_reg + 1'b1;
            end
            if (rx_rd_en)
            begin
                rv_reg       <= 1'b1;
                rx_tail_reg  <= bump(rx_tail_reg);
                rx_count_reg <= rx_count_reg - 1'b1;
            end
            if (tx_wr_en)
            begin
                tx_head_reg  <= bump(tx_head_reg);
                tx_count_reg <= tx_count_reg + 1'b1;
            end
            if (tx_rd_en)
            begin
                sv_reg       <= 1'b1;
                tx_tail_reg  <= bump(tx_tail_reg);
                tx_count_reg <= tx_count_reg - 1'b1;
            end
            if (ctrl.load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign status.out_busy = out_valid_reg && !out_ready;

    assign out_valid  = out_valid_reg;
    assign read_valid = read_valid_reg;
    assign read_data  = read_data_reg;
    assign send_valid = send_valid_reg;
    assign send_data  = send_data_reg;
    assign rx_pending = rx_pending_reg;
    assign tx_free    = tx_free_reg;
    assign overflow   = overflow_reg;

`ifndef ASSERT_OFF
    a_rx_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rx_count_reg <= LAST)
        else $error("receive fill count beyond capacity");

    a_tx_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        tx_count_reg <= LAST)
        else $error("transmit fill count beyond capacity");

    a_load_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |-> !(out_valid_reg && !out_ready))
        else $error("result loaded over an untaken beat");

    a_tx_push: assert property (@(posedge clk) disable iff (!rst_n)
        tx_wr_en |=> tx_count_reg == $past(tx_count_reg) + 1'b1)
        else $error("transmit push did not advance fill count");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (rx_count_reg == '0) |-> (rx_head_reg == rx_tail_reg))
        else $error("empty receive ring with unequal pointers");
`endif

endmodule

[hw/rtl/uart_dual_ring_buffer_unit.sv]
// Top level of the dual ring buffer unit: receive and transmit byte rings.
// Instantiates uart_drb_ctrl and uart_drb_datapath; uses uart_drb_pkg.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | cmd, data_byte, tx_room
//  out     | output    | out_valid / out_ready| read_valid, read_data, send_valid,
//          |           |                      | send_data, rx_pending, tx_free, overflow
//
// One event at a time: accept, ring update, transmit fetch, result load; in_ready
// stays low until the result is loaded. The transmit ring read is registered.
// Reset clears pointers, fill counts and out_valid; ring and payload registers are kept.
// A new event is taken while the previous result beat still waits; the load stalls
// only when that beat is still untaken.
`timescale 1ns / 1ps

module uart_dual_ring_buffer_unit
    import uart_drb_pkg::*;
#(
    parameter int RING_DEPTH = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] cmd,
    input  logic [7:0] data_byte,
    input  logic       tx_room,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       read_valid,
    output logic [7:0] read_data,
    output logic       send_valid,
    output logic [7:0] send_data,
    output logic       rx_pending,
    output logic [7:0] tx_free,
    output logic       overflow
);

    drb_ctrl_t   ctrl;
    drb_status_t status;

    uart_drb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .ctrl     (ctrl)
    );

    uart_drb_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .status     (status),
        .cmd        (cmd),
        .data_byte  (data_byte),
        .tx_room    (tx_room),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_valid (read_valid),
        .read_data  (read_data),
        .send_valid (send_valid),
        .send_data  (send_data),
        .rx_pending (rx_pending),
        .tx_free    (tx_free),
        .overflow   (overflow)
    );

endmodule
